// File: rtl/gswmd_pkg.sv
// ----------------------------------------------------------------------------
// gswmd_pkg: shared types and constants of the GPS speed window detector
// Holds the fix, result and state records, the motion status codes and the
// speed mark table.
// ----------------------------------------------------------------------------
package gswmd_pkg;

  localparam int WIN        = 5;
  localparam int SPEED_W    = 19;
  localparam int COURSE_W   = 16;
  localparam int TIME_W     = 32;
  localparam int SUM_W      = 22;
  localparam int MARK_TABLE = 30;
  localparam int NUM_MARKS  = 29;

  // floor(x / 5) == (x * DIV5_MUL) >> DIV5_SHIFT for every x below 2**22.
  localparam int DIV5_SHIFT = 24;
  localparam int DIV5_MUL_W = 22;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 22'd3355444;
  localparam int PROD_W = SUM_W + DIV5_MUL_W;

  localparam logic [SPEED_W-1:0] SLOW_LIMIT_RST = 19'd1000;

  typedef logic [SPEED_W-1:0] speed_t;

  localparam speed_t MARK_TAB [0:MARK_TABLE-1] = '{
    19'd5000,   19'd10000,  19'd20000,  19'd30000,  19'd40000,  19'd50000,
    19'd60000,  19'd70000,  19'd80000,  19'd90000,  19'd100000, 19'd110000,
    19'd120000, 19'd130000, 19'd140000, 19'd150000, 19'd160000, 19'd170000,
    19'd180000, 19'd190000, 19'd200000, 19'd210000, 19'd220000, 19'd230000,
    19'd240000, 19'd250000, 19'd260000, 19'd270000, 19'd280000, 19'd290000
  };

  typedef enum logic [1:0] {
    STAT_UNKNOWN = 2'd0,
    STAT_STOPPED = 2'd1,
    STAT_ACCEL   = 2'd2
  } status_t;

  typedef struct packed {
    speed_t                speed;
    logic [COURSE_W-1:0]   course;
    logic [TIME_W-1:0]     fix_time;
  } fix_t;

  typedef struct packed {
    speed_t            avg_speed;
    status_t           vehicle_state;
    status_t           measure_state;
    logic              start_event;
    logic [TIME_W-1:0] start_stamp;
    speed_t            crossed_mark;
  } result_t;

  // Index WIN-1 of both windows holds the newest fix.
  typedef struct packed {
    speed_t [WIN-1:0]  spd_win;
    logic [WIN-1:0]    cz_win;
    logic [TIME_W-1:0] prev_time;
    status_t           veh;
    status_t           meas;
    logic [TIME_W-1:0] start_time;
  } state_t;

endpackage

// File: rtl/gps_speed_window_motion_detector.sv
// ----------------------------------------------------------------------------
// gps_speed_window_motion_detector: five-fix speed window motion detector
// Takes GPS fixes and reports mean speed, motion status, start events and
// crossed speed marks, one result per fix.
// ----------------------------------------------------------------------------
// Usage:
//   Fixes enter on the in_ channel (speed, course, fix_time) and are taken at
//   an edge where in_valid is high and in_stall is low. Each fix produces
//   exactly one result on the out_ channel, taken where out_valid is high and
//   out_stall is low.
//   A fix is held in an input register, then the window update and all
//   decisions are made combinationally into the result register. One fix per
//   cycle is sustained as long as the receiver does not stall.
//   When the receiver stalls, the result register holds; one more fix waits
//   in the input register, after which in_stall is raised.
//   The user must write the slow speed limit (cfg_valid/cfg_data, cfg_ready
//   always high) only while no fix is in flight; the block does not enforce it.
//   Reset (rst_n low, synchronous) empties both registers, clears the speed
//   window, marks all window fixes as courseless, sets both statuses to
//   unknown, clears the times and loads a slow limit of 1000 m/h.
// ----------------------------------------------------------------------------
module gps_speed_window_motion_detector import gswmd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SPEED_W-1:0]  in_speed,
  input  logic [COURSE_W-1:0] in_course,
  input  logic [TIME_W-1:0]   in_fix_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SPEED_W-1:0]  out_avg_speed,
  output logic [1:0]          out_vehicle_state,
  output logic [1:0]          out_measure_state,
  output logic                out_start_event,
  output logic [TIME_W-1:0]   out_start_stamp,
  output logic [SPEED_W-1:0]  out_crossed_mark,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SPEED_W-1:0]  cfg_data
);

  logic    s1_valid_r;
  fix_t    s1_fix_r;
  logic    out_valid_r;
  result_t res_r;
  state_t  state_r;
  speed_t  slow_limit_r;

  state_t  state_nxt;
  result_t res_nxt;
  logic    advance;
  logic    in_take;

  gswmd_step u_step (
    .cur        (state_r),
    .fix        (s1_fix_r),
    .slow_limit (slow_limit_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  // The held fix moves on when the result register is empty or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      slow_limit_r <= SLOW_LIMIT_RST;
      state_r.spd_win    <= '0;
      state_r.cz_win     <= '1;
      state_r.prev_time  <= '0;
      state_r.veh        <= STAT_UNKNOWN;
      state_r.meas       <= STAT_UNKNOWN;
      state_r.start_time <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slow_limit_r <= cfg_data;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_fix_r.speed    <= in_speed;
      s1_fix_r.course   <= in_course;
      s1_fix_r.fix_time <= in_fix_time;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_avg_speed     = res_r.avg_speed;
  assign out_vehicle_state = res_r.vehicle_state;
  assign out_measure_state = res_r.measure_state;
  assign out_start_event   = res_r.start_event;
  assign out_start_stamp   = res_r.start_stamp;
  assign out_crossed_mark  = res_r.crossed_mark;

  a_start_sets_accel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.start_event) |->
      (res_r.vehicle_state == STAT_ACCEL && res_r.measure_state == STAT_ACCEL))
    else $error("start result without accelerating status");

  a_stop_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.vehicle_state == STAT_STOPPED) |->
      (res_r.measure_state == STAT_STOPPED))
    else $error("vehicle stopped but measurement not stopped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (!s1_valid_r || advance))
    else $error("input register overwritten while holding a fix");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed fix did not produce a result");

endmodule

// File: rtl/gswmd_step.sv
// ----------------------------------------------------------------------------
// gswmd_step: per-fix update logic
// Shifts one fix into the window, forms the five-fix mean, the stop and
// start decisions and the crossed speed mark, and returns the next state.
// ----------------------------------------------------------------------------
module gswmd_step import gswmd_pkg::*; (
  input  state_t cur,
  input  fix_t   fix,
  input  speed_t slow_limit,
  output state_t nxt,
  output result_t res
);

  logic [SUM_W-1:0]   sum;
  logic [PROD_W-1:0]  prod;
  logic               all_still;
  logic [SPEED_W:0]   pair_sum;
  speed_t             pair_mean;
  logic               start;
  speed_t             old_speed;
  speed_t             mark;

  always_comb begin
    nxt            = cur;
    nxt.spd_win    = {fix.speed, cur.spd_win[WIN-1:1]};
    nxt.cz_win     = {(fix.course == '0), cur.cz_win[WIN-1:1]};
    nxt.prev_time  = fix.fix_time;

    sum       = '0;
    all_still = 1'b1;
    for (int i = 0; i < WIN; i++) begin
      sum = sum + SUM_W'(nxt.spd_win[i]);
      if (!nxt.cz_win[i] || !(nxt.spd_win[i] < slow_limit)) begin
        all_still = 1'b0;
      end
    end
    prod = PROD_W'(sum) * PROD_W'(DIV5_MUL);

    if (all_still) begin
      nxt.veh = STAT_STOPPED;
    end
    if (nxt.veh == STAT_STOPPED) begin
      nxt.meas = STAT_STOPPED;
    end

    // The two fixes before this one decide whether the vehicle stood still.
    pair_sum  = {1'b0, cur.spd_win[WIN-1]} + {1'b0, cur.spd_win[WIN-2]};
    pair_mean = pair_sum[SPEED_W:1];
    start     = (fix.course != '0) && cur.cz_win[WIN-1] && (pair_mean < slow_limit);
    if (start) begin
      nxt.start_time = cur.prev_time;
      nxt.veh        = STAT_ACCEL;
      nxt.meas       = STAT_ACCEL;
    end

    // Scan from the top so the lowest mark crossed wins.
    old_speed = cur.spd_win[WIN-1];
    mark      = '0;
    for (int i = NUM_MARKS - 1; i >= 0; i--) begin
      if (fix.speed > MARK_TAB[i] && old_speed < MARK_TAB[i]) begin
        mark = MARK_TAB[i];
      end
    end

    res.avg_speed     = prod[DIV5_SHIFT +: SPEED_W];
    res.vehicle_state = nxt.veh;
    res.measure_state = nxt.meas;
    res.start_event   = start;
    res.start_stamp   = nxt.start_time;
    res.crossed_mark  = mark;
  end

endmodule
